// ===== design/wcl_pkg.sv =====
// shared types, sizes and operation codes for the workspace client list engine
// no dependencies; used by workspace_client_list_engine and its bench
`default_nettype none
package wcl_pkg;

  localparam int NUM_WORKSPACES = 9;
  localparam int LIST_DEPTH     = 64;
  localparam int ID_BITS        = 32;

  localparam int WS_W   = (NUM_WORKSPACES > 1) ? $clog2(NUM_WORKSPACES) : 1;
  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ID_W   = (ID_BITS < 32) ? ID_BITS : 32;
  localparam int DEPTH  = NUM_WORKSPACES * LIST_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  // operation codes
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_REMOVE  = 4'd1;
  localparam logic [3:0] OP_FOCUS   = 4'd2;
  localparam logic [3:0] OP_FSTEP   = 4'd3;
  localparam logic [3:0] OP_MSTEP   = 4'd4;
  localparam logic [3:0] OP_TFLOAT  = 4'd5;
  localparam logic [3:0] OP_TFULL   = 4'd6;
  localparam logic [3:0] OP_VIEW    = 4'd7;
  localparam logic [3:0] OP_SEND    = 4'd8;
  localparam logic [3:0] OP_REORDER = 4'd9;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] window_id;
    logic        step_back;
    logic [3:0]  target_ws;
    logic [5:0]  from_index;
    logic [5:0]  to_index;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  current_ws;
    logic [6:0]  entry_count;
    logic [31:0] selected_window;
    logic [5:0]  selected_index;
    logic        selected_floating;
    logic        selected_fullscreen;
  } out_t;

  // one stored list entry
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            flt;
    logic            ful;
  } entry_t;

  function automatic logic [ADDR_W-1:0] ram_addr(input logic [WS_W-1:0] ws,
                                                 input logic [IDX_W-1:0] idx);
    ram_addr = ADDR_W'(ws) * ADDR_W'(LIST_DEPTH) + ADDR_W'(idx);
  endfunction

endpackage
`default_nettype wire

// ===== design/wcl_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module wcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/workspace_client_list_engine.sv =====
// top level of the workspace client list engine: sequencer over one entry ram
// depends on wcl_pkg and wcl_ram
//
//   channel | ports                     | transfer
//   --------+---------------------------+------------------------------------
//   input   | start, busy, in_data      | start high while busy low
//   result  | out_valid, out_data       | one cycle strobe, cannot be stalled
//
// one operation at a time; busy stays high until its result is captured and
// the strobe follows in the first cycle with busy low.
// entries are reached through the single read port, a read state and then a
// check or write state per entry; a search stops at its match and a delete
// shifts from there. the result is read through S_OUT_WS, S_OUT_RD and
// S_OUT_CAP after the work, and remove walks all workspaces.
// reset (rst_n low, synchronous) empties every list; ram needs no clearing.
`default_nettype none
module workspace_client_list_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire wcl_pkg::in_t  in_data,
  output logic               out_valid,
  output wcl_pkg::out_t      out_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SC_RD   = 5'd1;
  localparam logic [4:0] S_SC_CHK  = 5'd2;
  localparam logic [4:0] S_SC_DONE = 5'd3;
  localparam logic [4:0] S_CP_RD   = 5'd4;
  localparam logic [4:0] S_CP_WR   = 5'd5;
  localparam logic [4:0] S_DEL_FIN = 5'd6;
  localparam logic [4:0] S_MV_B    = 5'd7;
  localparam logic [4:0] S_MV_W1   = 5'd8;
  localparam logic [4:0] S_MV_W2   = 5'd9;
  localparam logic [4:0] S_TG_MOD  = 5'd10;
  localparam logic [4:0] S_SD_CHK  = 5'd11;
  localparam logic [4:0] S_SD_RD   = 5'd12;
  localparam logic [4:0] S_SD_HOLD = 5'd13;
  localparam logic [4:0] S_RO_HOLD = 5'd14;
  localparam logic [4:0] S_RO_PUT  = 5'd15;
  localparam logic [4:0] S_OUT_WS  = 5'd16;
  localparam logic [4:0] S_OUT_RD  = 5'd17;
  localparam logic [4:0] S_OUT_CAP = 5'd18;

  localparam int IW = wcl_pkg::IDX_W;
  localparam int CW = wcl_pkg::CNT_W;
  localparam int WW = wcl_pkg::WS_W;

  logic [4:0]                  state_r, state_nxt;
  logic [3:0]                  op_r, op_nxt;
  logic [wcl_pkg::ID_W-1:0]    id_r, id_nxt;
  logic                        back_r, back_nxt;
  logic [WW-1:0]               tws_r, tws_nxt;
  logic [IW-1:0]               from_r, from_nxt;
  logic [IW-1:0]               to_r, to_nxt;
  logic [WW-1:0]               cw_r, cw_nxt;
  logic [WW-1:0]               ws_r, ws_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [IW-1:0]               stop_r, stop_nxt;
  logic                        fwd_r, fwd_nxt;
  logic                        found_r, found_nxt;
  logic                        ok_r, ok_nxt;
  wcl_pkg::entry_t             hold_r, hold_nxt;
  logic [CW-1:0]               lens_r [wcl_pkg::NUM_WORKSPACES];
  logic [IW-1:0]               sels_r [wcl_pkg::NUM_WORKSPACES];
  logic                        out_valid_r, out_valid_nxt;
  wcl_pkg::out_t               out_r, out_nxt;

  logic                        len_we, sel_we;
  logic [CW-1:0]               len_wd;
  logic [IW-1:0]               sel_wd;

  logic                        ram_we;
  logic [wcl_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  wcl_pkg::entry_t             ram_wdata, ram_rdata, tg_e;

  logic [CW-1:0]               n;
  logic [IW-1:0]               sel, last_idx, nx;
  logic                        back_sel;
  logic [wcl_pkg::ID_W-1:0]    in_id;
  logic [8:0]                  n9, from9, to9;
  logic                        tws_ok;

  wcl_ram #(
    .WIDTH($bits(wcl_pkg::entry_t)),
    .DEPTH(wcl_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // view of the working workspace
  assign n        = lens_r[ws_r];
  assign sel      = sels_r[ws_r];
  assign last_idx = IW'(n - CW'(1));
  assign back_sel = (state_r == S_IDLE) ? in_data.step_back : back_r;
  assign in_id    = in_data.window_id[wcl_pkg::ID_W-1:0];
  assign n9       = 9'(n);
  assign from9    = 9'(in_data.from_index);
  assign to9      = 9'(in_data.to_index);
  assign tws_ok   = 5'(in_data.target_ws) < 5'(wcl_pkg::NUM_WORKSPACES);

  // neighbor of the selection with wrap
  always_comb begin
    if (back_sel) begin
      nx = (sel == '0) ? last_idx : sel - IW'(1);
    end else begin
      nx = (sel == last_idx) ? '0 : sel + IW'(1);
    end
  end

  // toggled entry for the mark operations
  always_comb begin
    tg_e = ram_rdata;
    if (op_r == wcl_pkg::OP_TFLOAT) begin
      tg_e.flt = ~ram_rdata.flt;
      if (tg_e.flt) begin
        tg_e.ful = 1'b0;
      end
    end else begin
      tg_e.ful = ~ram_rdata.ful;
      if (tg_e.ful) begin
        tg_e.flt = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    back_nxt      = back_r;
    tws_nxt       = tws_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    cw_nxt        = cw_r;
    ws_nxt        = ws_r;
    idx_nxt       = idx_r;
    stop_nxt      = stop_r;
    fwd_nxt       = fwd_r;
    found_nxt     = found_r;
    ok_nxt        = ok_r;
    hold_nxt      = hold_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    len_we        = 1'b0;
    len_wd        = n;
    sel_we        = 1'b0;
    sel_wd        = sel;
    ram_we        = 1'b0;
    ram_waddr     = wcl_pkg::ram_addr(ws_r, idx_r);
    ram_wdata     = ram_rdata;
    ram_raddr     = wcl_pkg::ram_addr(ws_r, sel);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_data.operation;
          id_nxt    = in_id;
          back_nxt  = in_data.step_back;
          tws_nxt   = in_data.target_ws[WW-1:0];
          from_nxt  = in_data.from_index[IW-1:0];
          to_nxt    = in_data.to_index[IW-1:0];
          ok_nxt    = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_OUT_WS;
          case (in_data.operation)
            wcl_pkg::OP_ADD: begin
              if (in_id != '0 && n < CW'(wcl_pkg::LIST_DEPTH)) begin
                state_nxt = S_SC_RD;
              end
            end
            wcl_pkg::OP_REMOVE: begin
              if (in_id != '0) begin
                ws_nxt    = '0;
                state_nxt = S_SC_RD;
              end
            end
            wcl_pkg::OP_FOCUS: begin
              if (in_id != '0) begin
                state_nxt = S_SC_RD;
              end
            end
            wcl_pkg::OP_FSTEP: begin
              if (n >= CW'(2)) begin
                sel_we = 1'b1;
                sel_wd = nx;
                ok_nxt = 1'b1;
              end
            end
            wcl_pkg::OP_MSTEP: begin
              if (n >= CW'(2)) begin
                state_nxt = S_MV_B;
              end
            end
            wcl_pkg::OP_TFLOAT, wcl_pkg::OP_TFULL: begin
              if (n != '0) begin
                state_nxt = S_TG_MOD;
              end
            end
            wcl_pkg::OP_VIEW: begin
              if (tws_ok) begin
                cw_nxt = in_data.target_ws[WW-1:0];
                ok_nxt = 1'b1;
              end
            end
            wcl_pkg::OP_SEND: begin
              if (n != '0 && tws_ok) begin
                ws_nxt    = in_data.target_ws[WW-1:0];
                state_nxt = S_SD_CHK;
              end
            end
            wcl_pkg::OP_REORDER: begin
              if (from9 != to9 && from9 < n9 && to9 < n9) begin
                ram_raddr = wcl_pkg::ram_addr(ws_r, in_data.from_index[IW-1:0]);
                state_nxt = S_RO_HOLD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // linear search of the working list for id_r
      S_SC_RD: begin
        ram_raddr = wcl_pkg::ram_addr(ws_r, idx_r);
        if (n == '0) begin
          found_nxt = 1'b0;
          state_nxt = S_SC_DONE;
        end else begin
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (ram_rdata.id == id_r) begin
          found_nxt = 1'b1;
          state_nxt = S_SC_DONE;
        end else if (idx_r == last_idx) begin
          found_nxt = 1'b0;
          state_nxt = S_SC_DONE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_SC_DONE: begin
        state_nxt = S_OUT_WS;
        case (op_r)
          wcl_pkg::OP_ADD: begin
            if (!found_r) begin
              ram_we    = 1'b1;
              ram_waddr = wcl_pkg::ram_addr(ws_r, IW'(n));
              ram_wdata = '{id: id_r, flt: 1'b0, ful: 1'b0};
              len_we    = 1'b1;
              len_wd    = n + CW'(1);
              sel_we    = 1'b1;
              sel_wd    = IW'(n);
              ok_nxt    = 1'b1;
            end
          end
          wcl_pkg::OP_REMOVE: begin
            if (found_r) begin
              ok_nxt = 1'b1;
              if (CW'(idx_r) + CW'(1) < n) begin
                fwd_nxt   = 1'b1;
                stop_nxt  = IW'(n - CW'(2));
                state_nxt = S_CP_RD;
              end else begin
                state_nxt = S_DEL_FIN;
              end
            end else if (ws_r != WW'(wcl_pkg::NUM_WORKSPACES - 1)) begin
              ws_nxt    = ws_r + WW'(1);
              idx_nxt   = '0;
              state_nxt = S_SC_RD;
            end
          end
          wcl_pkg::OP_FOCUS: begin
            if (found_r) begin
              sel_we = 1'b1;
              sel_wd = idx_r;
              ok_nxt = 1'b1;
            end
          end
          wcl_pkg::OP_SEND: begin
            ram_we    = 1'b1;
            ram_wdata = hold_r;
            ok_nxt    = 1'b1;
            if (!found_r) begin
              ram_waddr = wcl_pkg::ram_addr(ws_r, IW'(n));
              len_we    = 1'b1;
              len_wd    = n + CW'(1);
              sel_we    = 1'b1;
              sel_wd    = IW'(n);
            end
          end
          default: begin
          end
        endcase
      end

      // copy one entry toward idx_r from its neighbor
      S_CP_RD: begin
        ram_raddr = wcl_pkg::ram_addr(ws_r, fwd_r ? idx_r + IW'(1) : idx_r - IW'(1));
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        ram_we = 1'b1;
        if (idx_r == stop_r) begin
          state_nxt = (op_r == wcl_pkg::OP_REORDER) ? S_RO_PUT : S_DEL_FIN;
        end else begin
          idx_nxt   = fwd_r ? idx_r + IW'(1) : idx_r - IW'(1);
          state_nxt = S_CP_RD;
        end
      end

      // shorten the list, clamp its selection and go on to the next search or the result
      S_DEL_FIN: begin
        len_we = 1'b1;
        len_wd = n - CW'(1);
        sel_we = 1'b1;
        if (n == CW'(1)) begin
          sel_wd = '0;
        end else if (CW'(sel) >= n - CW'(1)) begin
          sel_wd = IW'(n - CW'(2));
        end
        idx_nxt = '0;
        if (op_r == wcl_pkg::OP_SEND) begin
          ws_nxt    = tws_r;
          id_nxt    = hold_r.id;
          state_nxt = S_SC_RD;
        end else if (ws_r != WW'(wcl_pkg::NUM_WORKSPACES - 1)) begin
          ws_nxt    = ws_r + WW'(1);
          state_nxt = S_SC_RD;
        end else begin
          state_nxt = S_OUT_WS;
        end
      end

      // swap with neighbor
      S_MV_B: begin
        hold_nxt  = ram_rdata;
        ram_raddr = wcl_pkg::ram_addr(ws_r, nx);
        state_nxt = S_MV_W1;
      end
      S_MV_W1: begin
        ram_we    = 1'b1;
        ram_waddr = wcl_pkg::ram_addr(ws_r, sel);
        state_nxt = S_MV_W2;
      end
      S_MV_W2: begin
        ram_we    = 1'b1;
        ram_waddr = wcl_pkg::ram_addr(ws_r, nx);
        ram_wdata = hold_r;
        sel_we    = 1'b1;
        sel_wd    = nx;
        ok_nxt    = 1'b1;
        state_nxt = S_OUT_WS;
      end

      // mark toggles
      S_TG_MOD: begin
        ram_we    = 1'b1;
        ram_waddr = wcl_pkg::ram_addr(ws_r, sel);
        ram_wdata = tg_e;
        ok_nxt    = 1'b1;
        state_nxt = S_OUT_WS;
      end

      // send: capacity check on target, then take the selected entry out
      S_SD_CHK: begin
        ws_nxt = cw_r;
        if (ws_r != cw_r && n >= CW'(wcl_pkg::LIST_DEPTH)) begin
          state_nxt = S_OUT_WS;
        end else begin
          state_nxt = S_SD_RD;
        end
      end
      S_SD_RD: begin
        state_nxt = S_SD_HOLD;
      end
      S_SD_HOLD: begin
        hold_nxt = ram_rdata;
        idx_nxt  = sel;
        if (CW'(sel) + CW'(1) < n) begin
          fwd_nxt   = 1'b1;
          stop_nxt  = IW'(n - CW'(2));
          state_nxt = S_CP_RD;
        end else begin
          state_nxt = S_DEL_FIN;
        end
      end

      // reorder: hold source, shift the span, drop it at the destination
      S_RO_HOLD: begin
        hold_nxt  = ram_rdata;
        idx_nxt   = from_r;
        fwd_nxt   = to_r > from_r;
        stop_nxt  = (to_r > from_r) ? to_r - IW'(1) : to_r + IW'(1);
        state_nxt = S_CP_RD;
      end
      S_RO_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = wcl_pkg::ram_addr(ws_r, to_r);
        ram_wdata = hold_r;
        sel_we    = 1'b1;
        sel_wd    = to_r;
        ok_nxt    = 1'b1;
        state_nxt = S_OUT_WS;
      end

      // result: read the selection of the viewed list
      S_OUT_WS: begin
        ws_nxt    = cw_r;
        state_nxt = S_OUT_RD;
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_CAP;
      end
      S_OUT_CAP: begin
        out_nxt.status      = ~ok_r;
        out_nxt.current_ws  = 4'(cw_r);
        out_nxt.entry_count = 7'(n);
        if (n != '0) begin
          out_nxt.selected_window     = 32'(ram_rdata.id);
          out_nxt.selected_index      = 6'(sel);
          out_nxt.selected_floating   = ram_rdata.flt;
          out_nxt.selected_fullscreen = ram_rdata.ful;
        end else begin
          out_nxt.selected_window     = '0;
          out_nxt.selected_index      = '0;
          out_nxt.selected_floating   = 1'b0;
          out_nxt.selected_fullscreen = 1'b0;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cw_r        <= '0;
      ws_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < wcl_pkg::NUM_WORKSPACES; i++) begin
        lens_r[i] <= '0;
        sels_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cw_r        <= cw_nxt;
      ws_r        <= ws_nxt;
      out_valid_r <= out_valid_nxt;
      if (len_we) begin
        lens_r[ws_r] <= len_wd;
      end
      if (sel_we) begin
        sels_r[ws_r] <= sel_wd;
      end
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    id_r    <= id_nxt;
    back_r  <= back_nxt;
    tws_r   <= tws_nxt;
    from_r  <= from_nxt;
    to_r    <= to_nxt;
    idx_r   <= idx_nxt;
    stop_r  <= stop_nxt;
    fwd_r   <= fwd_nxt;
    found_r <= found_nxt;
    ok_r    <= ok_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer did not start work");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= 7'(wcl_pkg::LIST_DEPTH)))
    else $error("entry count out of range");
  a_sel_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.entry_count != '0) |->
      (7'(out_data.selected_index) < out_data.entry_count))
    else $error("selection beyond list end");
`endif

endmodule
`default_nettype wire

// ===== bench/workspace_client_list_engine_tb.sv =====
// self-checking bench for workspace_client_list_engine: directed and random operations
// depends on wcl_pkg and the engine rtl; predicts each result with its own list model
`default_nettype none
module workspace_client_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  wcl_pkg::in_t in_data = '0;
  logic out_valid;
  wcl_pkg::out_t out_data;

  workspace_client_list_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // shadow copy of the lists
  logic [31:0] win_ids [wcl_pkg::NUM_WORKSPACES][wcl_pkg::LIST_DEPTH];
  logic        win_flt [wcl_pkg::NUM_WORKSPACES][wcl_pkg::LIST_DEPTH];
  logic        win_ful [wcl_pkg::NUM_WORKSPACES][wcl_pkg::LIST_DEPTH];
  int          ws_len [wcl_pkg::NUM_WORKSPACES];
  int          ws_sel [wcl_pkg::NUM_WORKSPACES];
  int          shown_ws;

  wcl_pkg::in_t  pending_ops[$];
  wcl_pkg::out_t expected_views[$];
  int   idle_pct = 0;
  int   errors = 0;
  int   checked = 0;
  int   op_hits [16];
  int   applied = 0;

  function automatic int find_win(int ws, logic [31:0] id);
    for (int i = 0; i < ws_len[ws]; i++)
      if (win_ids[ws][i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_at(int ws, int idx);
    for (int i = idx; i + 1 < ws_len[ws]; i++) begin
      win_ids[ws][i] = win_ids[ws][i+1];
      win_flt[ws][i] = win_flt[ws][i+1];
      win_ful[ws][i] = win_ful[ws][i+1];
    end
    ws_len[ws]--;
    if (ws_len[ws] == 0) ws_sel[ws] = 0;
    else if (ws_sel[ws] >= ws_len[ws]) ws_sel[ws] = ws_len[ws] - 1;
  endfunction

  function automatic bit push_win(int ws, logic [31:0] id);
    int n;
    n = ws_len[ws];
    if (n >= wcl_pkg::LIST_DEPTH || find_win(ws, id) >= 0) return 0;
    win_ids[ws][n] = id;
    win_flt[ws][n] = 1'b0;
    win_ful[ws][n] = 1'b0;
    ws_len[ws] = n + 1;
    ws_sel[ws] = n;
    return 1;
  endfunction

  // apply one operation to the shadow lists and return the view after it
  function automatic wcl_pkg::out_t next_view(wcl_pkg::in_t c);
    int cw, n, s, nx, p, tws, fr, to;
    bit ok;
    logic [31:0] tid;
    logic tf, tF;
    wcl_pkg::out_t r;
    cw = shown_ws; n = ws_len[cw]; s = ws_sel[cw]; ok = 0;
    tws = c.target_ws; fr = c.from_index; to = c.to_index;
    case (c.operation)
      wcl_pkg::OP_ADD: ok = (c.window_id != 0) && push_win(cw, c.window_id);
      wcl_pkg::OP_REMOVE:
        if (c.window_id != 0)
          for (int w = 0; w < wcl_pkg::NUM_WORKSPACES; w++) begin
            p = find_win(w, c.window_id);
            if (p >= 0) begin
              drop_at(w, p);
              ok = 1;
            end
          end
      wcl_pkg::OP_FOCUS:
        if (c.window_id != 0) begin
          p = find_win(cw, c.window_id);
          if (p >= 0) begin
            ws_sel[cw] = p;
            ok = 1;
          end
        end
      wcl_pkg::OP_FSTEP, wcl_pkg::OP_MSTEP:
        if (n >= 2) begin
          nx = c.step_back ? (s + n - 1) % n : (s + 1) % n;
          if (c.operation == wcl_pkg::OP_MSTEP) begin
            tid = win_ids[cw][s]; tf = win_flt[cw][s]; tF = win_ful[cw][s];
            win_ids[cw][s] = win_ids[cw][nx];
            win_flt[cw][s] = win_flt[cw][nx];
            win_ful[cw][s] = win_ful[cw][nx];
            win_ids[cw][nx] = tid; win_flt[cw][nx] = tf; win_ful[cw][nx] = tF;
          end
          ws_sel[cw] = nx;
          ok = 1;
        end
      wcl_pkg::OP_TFLOAT:
        if (n != 0) begin
          win_flt[cw][s] = ~win_flt[cw][s];
          if (win_flt[cw][s]) win_ful[cw][s] = 1'b0;
          ok = 1;
        end
      wcl_pkg::OP_TFULL:
        if (n != 0) begin
          win_ful[cw][s] = ~win_ful[cw][s];
          if (win_ful[cw][s]) win_flt[cw][s] = 1'b0;
          ok = 1;
        end
      wcl_pkg::OP_VIEW:
        if (tws < wcl_pkg::NUM_WORKSPACES) begin
          shown_ws = tws;
          ok = 1;
        end
      wcl_pkg::OP_SEND:
        if (n != 0 && tws < wcl_pkg::NUM_WORKSPACES &&
            !(tws != cw && ws_len[tws] >= wcl_pkg::LIST_DEPTH)) begin
          tid = win_ids[cw][s]; tf = win_flt[cw][s]; tF = win_ful[cw][s];
          drop_at(cw, s);
          void'(push_win(tws, tid));
          p = find_win(tws, tid);
          if (p >= 0) begin
            win_flt[tws][p] = tf;
            win_ful[tws][p] = tF;
          end
          ok = 1;
        end
      wcl_pkg::OP_REORDER:
        if (fr != to && fr < n && to < n) begin
          tid = win_ids[cw][fr]; tf = win_flt[cw][fr]; tF = win_ful[cw][fr];
          if (to > fr)
            for (int i = fr; i < to; i++) begin
              win_ids[cw][i] = win_ids[cw][i+1];
              win_flt[cw][i] = win_flt[cw][i+1];
              win_ful[cw][i] = win_ful[cw][i+1];
            end
          else
            for (int i = fr; i > to; i--) begin
              win_ids[cw][i] = win_ids[cw][i-1];
              win_flt[cw][i] = win_flt[cw][i-1];
              win_ful[cw][i] = win_ful[cw][i-1];
            end
          win_ids[cw][to] = tid; win_flt[cw][to] = tf; win_ful[cw][to] = tF;
          ws_sel[cw] = to;
          ok = 1;
        end
      default: ok = 0;
    endcase
    cw = shown_ws; n = ws_len[cw]; s = ws_sel[cw];
    r = '0;
    r.status = ~ok;
    r.current_ws = 4'(cw);
    r.entry_count = 7'(n);
    if (n > 0) begin
      r.selected_window = win_ids[cw][s];
      r.selected_index = 6'(s);
      r.selected_floating = win_flt[cw][s];
      r.selected_fullscreen = win_ful[cw][s];
    end
    if (ok) applied++;
    return r;
  endfunction

  // driver: predict on each transfer, then offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        op_hits[in_data.operation]++;
        expected_views.push_back(next_view(in_data));
      end
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_data <= pending_ops.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic field_err(string name, logic [31:0] e, logic [31:0] a);
    $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
    errors++;
  endtask

  // monitor: every strobe is checked against the oldest expectation
  always @(posedge clk) begin
    wcl_pkg::out_t e;
    if (rst_n && out_valid) begin
      if (expected_views.size() == 0) begin
        $display("%0t unexpected result, expected none actual %p", $time, out_data);
        errors++;
      end else begin
        e = expected_views.pop_front();
        checked++;
        if (e.status != out_data.status)
          field_err("status", 32'(e.status), 32'(out_data.status));
        if (e.current_ws != out_data.current_ws)
          field_err("current_ws", 32'(e.current_ws), 32'(out_data.current_ws));
        if (e.entry_count != out_data.entry_count)
          field_err("entry_count", 32'(e.entry_count), 32'(out_data.entry_count));
        if (e.selected_window != out_data.selected_window)
          field_err("selected_window", e.selected_window, out_data.selected_window);
        if (e.selected_index != out_data.selected_index)
          field_err("selected_index", 32'(e.selected_index),
                    32'(out_data.selected_index));
        if (e.selected_floating != out_data.selected_floating)
          field_err("selected_floating", 32'(e.selected_floating),
                    32'(out_data.selected_floating));
        if (e.selected_fullscreen != out_data.selected_fullscreen)
          field_err("selected_fullscreen", 32'(e.selected_fullscreen),
                    32'(out_data.selected_fullscreen));
      end
    end
  end

  function automatic wcl_pkg::in_t mk(logic [3:0] op, logic [31:0] id, logic back,
                                      logic [3:0] tws, logic [5:0] fr, logic [5:0] to);
    wcl_pkg::in_t c;
    c.operation = op; c.window_id = id; c.step_back = back;
    c.target_ws = tws; c.from_index = fr; c.to_index = to;
    return c;
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 31))
      0: return 32'd0;
      1, 2: return $urandom;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    case ($urandom_range(0, 7))
      0: return 6'($urandom_range(0, 63));
      1, 2: return 6'($urandom_range(0, 15));
      default: return 6'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic wcl_pkg::in_t rand_op();
    int r;
    logic [3:0] op;
    r = $urandom_range(0, 99);
    if (r < 25) op = wcl_pkg::OP_ADD;
    else if (r < 35) op = wcl_pkg::OP_REMOVE;
    else if (r < 45) op = wcl_pkg::OP_FOCUS;
    else if (r < 55) op = wcl_pkg::OP_FSTEP;
    else if (r < 62) op = wcl_pkg::OP_MSTEP;
    else if (r < 68) op = wcl_pkg::OP_TFLOAT;
    else if (r < 74) op = wcl_pkg::OP_TFULL;
    else if (r < 82) op = wcl_pkg::OP_VIEW;
    else if (r < 90) op = wcl_pkg::OP_SEND;
    else if (r < 97) op = wcl_pkg::OP_REORDER;
    else op = 4'($urandom_range(10, 15));
    return mk(op, pick_id(), 1'($urandom_range(0, 1)),
              4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                             : $urandom_range(0, 8)),
              pick_index(), pick_index());
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || start || expected_views.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int w = 0; w < wcl_pkg::NUM_WORKSPACES; w++) begin
      ws_len[w] = 0;
      ws_sel[w] = 0;
    end
    shown_ws = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: id extremes, every operation and the ignore cases
    pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'd1, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'd1, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_FOCUS, 32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_FOCUS, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_FSTEP, 32'd0, 1, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_FSTEP, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_MSTEP, 32'd0, 1, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_MSTEP, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_TFLOAT, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_TFULL, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_TFULL, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_VIEW, 32'd0, 0, 4'd9, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_VIEW, 32'd0, 0, 4'd15, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_SEND, 32'd0, 0, 4'd0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_SEND, 32'd0, 0, 4'd8, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_REORDER, 32'd0, 0, 0, 6'd0, 6'd0));
    pending_ops.push_back(mk(wcl_pkg::OP_REORDER, 32'd0, 0, 0, 6'd63, 6'd0));
    pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'd2, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_REORDER, 32'd0, 0, 0, 6'd1, 6'd0));
    pending_ops.push_back(mk(4'd10, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(4'd15, 32'hFFFF_FFFF, 1, 4'd15, 6'd63, 6'd63));
    pending_ops.push_back(mk(wcl_pkg::OP_REMOVE, 32'd0, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_REMOVE, 32'd1, 0, 0, 0, 0));
    drain();

    // fill workspace 8 to capacity, then probe the full cases
    pending_ops.push_back(mk(wcl_pkg::OP_VIEW, 32'd0, 0, 4'd8, 0, 0));
    for (int i = 0; i < wcl_pkg::LIST_DEPTH + 2; i++)
      pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'(100 + i), 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_REORDER, 32'd0, 0, 0, 6'd0, 6'd63));
    pending_ops.push_back(mk(wcl_pkg::OP_REORDER, 32'd0, 0, 0, 6'd63, 6'd2));
    pending_ops.push_back(mk(wcl_pkg::OP_SEND, 32'd0, 0, 4'd8, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_VIEW, 32'd0, 0, 4'd2, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'd100, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_SEND, 32'd0, 0, 4'd8, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_ADD, 32'd7, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_SEND, 32'd0, 0, 4'd8, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_REMOVE, 32'd100, 0, 0, 0, 0));
    pending_ops.push_back(mk(wcl_pkg::OP_VIEW, 32'd0, 0, 4'd0, 0, 0));
    drain();

    // random phases with different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 86 : (ph == 3) ? 37 : 0;
      for (int i = 0; i < 160; i++)
        pending_ops.push_back(rand_op());
      drain();
    end
    repeat (20) @(posedge clk);

    $display("covered %0d results, %0d applied; ops add %0d remove %0d send %0d reorder %0d",
             checked, applied, op_hits[wcl_pkg::OP_ADD], op_hits[wcl_pkg::OP_REMOVE],
             op_hits[wcl_pkg::OP_SEND], op_hits[wcl_pkg::OP_REORDER]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/wcl_pkg.sv
design/wcl_ram.sv
design/workspace_client_list_engine.sv
bench/workspace_client_list_engine_tb.sv
